FILE: rtl/frs_pkg.sv
// Shared types, constants and a helper function of the fixed rate linear resampler.
package frs_pkg;

   localparam int MAX_BURST_DEF     = 16;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int LANES             = 6;
   localparam int TS_W              = 64;
   localparam int GAP_W             = 40;
   localparam int PER_W             = 32;
   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [31:0] PERIOD_RESET  = 32'd1000000;
   localparam logic [39:0] MAX_GAP_RESET = 40'd4000000;
   localparam logic [7:0]  FLAG_ENV = 8'h02;
   localparam logic [7:0]  FLAG_LOC = 8'h01;

   typedef enum logic {
      CSR_PERIOD  = 1'b0,
      CSR_MAX_GAP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [63:0]        timestamp_ns;
      logic [15:0]        skew_ms;
      logic [7:0]         flag_bits;
      logic signed [31:0] rms_value;
      logic signed [31:0] peak_value;
      logic signed [31:0] kurtosis_value;
      logic signed [31:0] band_value;
      logic signed [31:0] env_value;
      logic signed [31:0] loc_value;
   } frs_req_type;

   typedef struct packed {
      logic [63:0]        out_timestamp_ns;
      logic [15:0]        out_skew_ms;
      logic [7:0]         out_flags;
      logic signed [31:0] out_rms;
      logic signed [31:0] out_peak;
      logic signed [31:0] out_kurtosis;
      logic signed [31:0] out_band;
      logic signed [31:0] out_env;
      logic signed [31:0] out_loc;
      logic               last;
   } frs_rsp_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? ALL_ONES : s[63:0];
   endfunction

endpackage

FILE: rtl/frs_divider.sv
// Restoring radix-2 divider for 64-bit operands, one quotient bit per cycle.
module frs_divider import frs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 64'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/fixed_rate_linear_resampler.sv
// Top level of the fixed rate linear resampler: sequencer, lane multiplier and state.
// Each accepted word runs through a sequencer that shares one radix-2 divider
// and one lane multiplier. A word that restarts the grid runs one division to
// align the next grid point. A word inside the grid takes, per emitted result,
// one loop step, the fraction division, a multiply and an accumulate step for
// each of the six lanes and the hand-over of the result, for up to MAX_BURST
// results, plus a division to realign the grid when the burst limit cut it
// short. The divider is the dominant cost. The block accepts no word while busy.
module fixed_rate_linear_resampler import frs_pkg::*; #(
   parameter int MAX_BURST     = MAX_BURST_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  frs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output frs_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [39:0] csr_data
);

   localparam int CW = $clog2(MAX_BURST + 1);
   localparam int FW = FRACTION_BITS + 1;
   localparam int PW = 33 + FW;
   localparam logic [63:0] ONE_FRAC = 64'(1) << FRACTION_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_RESTART, S_LOOP, S_FRAC, S_MUL, S_ACC, S_EMIT, S_FINISH, S_ADJ
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        period_ff, period_in;
   logic [39:0]        gap_ff, gap_in;
   logic               have_prev_ff, have_prev_in;
   logic [63:0]        prev_ts_ff, prev_ts_in;
   logic [15:0]        prev_skew_ff, prev_skew_in;
   logic [7:0]         prev_flags_ff, prev_flags_in;
   logic signed [31:0] prev_val_ff [LANES];
   logic signed [31:0] prev_val_in [LANES];
   logic [63:0]        ng_ff, ng_in;
   logic [63:0]        ts_ff, ts_in;
   logic [15:0]        skew_ff, skew_in;
   logic [7:0]         flags_ff, flags_in;
   logic signed [31:0] cur_ff [LANES];
   logic signed [31:0] cur_in [LANES];
   logic signed [31:0] mix_ff [LANES];
   logic signed [31:0] mix_in [LANES];
   logic [63:0]        span_ff, span_in;
   logic [63:0]        g_ff, g_in;
   logic [15:0]        oskew_ff, oskew_in;
   logic [7:0]         oflags_ff, oflags_in;
   logic [FW-1:0]      frac_ff, frac_in;
   logic [2:0]         lane_ff, lane_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               ended_ff, ended_in;
   logic               rsp_valid_ff, rsp_valid_in;
   frs_rsp_type        rsp_ff, rsp_in;

   logic        div_start;
   logic [63:0] div_dividend, div_divisor;
   logic        div_done;
   logic [63:0] div_quo, div_rem;
   logic [63:0] per_eff;
   logic [63:0] off;
   logic [63:0] ceil_t;
   logic signed [32:0] diff;
   logic signed [PW-1:0] shifted;

   frs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      gap_in        = gap_ff;
      have_prev_in  = have_prev_ff;
      prev_ts_in    = prev_ts_ff;
      prev_skew_in  = prev_skew_ff;
      prev_flags_in = prev_flags_ff;
      prev_val_in   = prev_val_ff;
      ng_in         = ng_ff;
      ts_in         = ts_ff;
      skew_in       = skew_ff;
      flags_in      = flags_ff;
      cur_in        = cur_ff;
      mix_in        = mix_ff;
      span_in       = span_ff;
      g_in          = g_ff;
      oskew_in      = oskew_ff;
      oflags_in     = oflags_ff;
      frac_in       = frac_ff;
      lane_in       = lane_ff;
      prod_in       = prod_ff;
      cnt_in        = cnt_ff;
      ended_in      = ended_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      div_start     = 1'b0;
      div_dividend  = ts_ff;
      per_eff       = {32'd0, (period_ff == '0) ? 32'd1 : period_ff};
      div_divisor   = per_eff;
      ceil_t        = (div_rem == '0) ? ts_ff : sat_add(ts_ff, per_eff - div_rem);
      off           = (g_ff >= prev_ts_ff) ? g_ff - prev_ts_ff : '0;
      if (off > span_ff) begin
         off = span_ff;
      end
      diff    = {cur_ff[lane_ff][31], cur_ff[lane_ff]} -
                {prev_val_ff[lane_ff][31], prev_val_ff[lane_ff]};
      shifted = prod_ff >>> FRACTION_BITS;

      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PERIOD:  period_in = csr_data[31:0];
            CSR_MAX_GAP: gap_in    = csr_data;
            default:     gap_in    = gap_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_data.timestamp_ns != '0) begin
               ts_in    = req_data.timestamp_ns;
               skew_in  = req_data.skew_ms;
               flags_in = req_data.flag_bits;
               cur_in[0] = req_data.rms_value;
               cur_in[1] = req_data.peak_value;
               cur_in[2] = req_data.kurtosis_value;
               cur_in[3] = req_data.band_value;
               cur_in[4] = req_data.env_value;
               cur_in[5] = req_data.loc_value;
               div_dividend = req_data.timestamp_ns;
               span_in   = req_data.timestamp_ns - prev_ts_ff;
               oskew_in  = (prev_skew_ff > req_data.skew_ms) ? prev_skew_ff : req_data.skew_ms;
               oflags_in = prev_flags_ff & req_data.flag_bits;
               cnt_in    = '0;
               ended_in  = 1'b0;
               if (!have_prev_ff) begin
                  div_start = 1'b1;
                  state_in  = S_FIRST;
               end else if (req_data.timestamp_ns <= prev_ts_ff ||
                            (req_data.timestamp_ns - prev_ts_ff) > {24'd0, gap_ff}) begin
                  div_start = 1'b1;
                  state_in  = S_RESTART;
               end else begin
                  state_in = S_LOOP;
               end
            end
         end
         S_FIRST, S_RESTART: begin
            if (div_done) begin
               have_prev_in  = 1'b1;
               prev_ts_in    = ts_ff;
               prev_skew_in  = skew_ff;
               prev_flags_in = flags_ff;
               prev_val_in   = cur_ff;
               ng_in         = ceil_t;
               state_in      = S_IDLE;
               if (state_ff == S_FIRST && ceil_t == ts_ff) begin
                  ng_in                     = sat_add(ts_ff, per_eff);
                  rsp_in.out_timestamp_ns   = ts_ff;
                  rsp_in.out_skew_ms        = skew_ff;
                  rsp_in.out_flags          = flags_ff;
                  rsp_in.out_rms            = cur_ff[0];
                  rsp_in.out_peak           = cur_ff[1];
                  rsp_in.out_kurtosis       = cur_ff[2];
                  rsp_in.out_band           = cur_ff[3];
                  rsp_in.out_env = ((flags_ff & FLAG_ENV) != '0) ? cur_ff[4] : '0;
                  rsp_in.out_loc = ((flags_ff & FLAG_LOC) != '0) ? cur_ff[5] : '0;
                  rsp_in.last               = 1'b1;
                  rsp_valid_in              = 1'b1;
                  ended_in                  = 1'b1;
                  state_in                  = S_EMIT;
               end
            end
         end
         S_LOOP: begin
            if (cnt_ff < CW'(MAX_BURST) && ng_ff <= ts_ff) begin
               g_in     = ng_ff;
               state_in = S_FRAC;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FRAC: begin
            div_dividend = off << FRACTION_BITS;
            div_divisor  = span_ff;
            if (lane_ff == 3'd0 && !div_done && frac_ff == '1) begin
               state_in = S_FRAC;
            end
            if (div_done) begin
               frac_in  = (div_quo > ONE_FRAC) ? ONE_FRAC[FW-1:0] : div_quo[FW-1:0];
               lane_in  = '0;
               state_in = S_MUL;
            end else if (frac_ff != '1) begin
               div_start = 1'b1;
               frac_in   = '1;
            end
         end
         S_MUL: begin
            prod_in  = PW'(diff) * $signed({1'b0, frac_ff});
            state_in = S_ACC;
         end
         S_ACC: begin
            mix_in[lane_ff] = prev_val_ff[lane_ff] + shifted[31:0];
            if (lane_ff == 3'(LANES - 1)) begin
               rsp_in.out_timestamp_ns = g_ff;
               rsp_in.out_skew_ms      = oskew_ff;
               rsp_in.out_flags        = oflags_ff;
               rsp_in.out_rms          = mix_ff[0];
               rsp_in.out_peak         = mix_ff[1];
               rsp_in.out_kurtosis     = mix_ff[2];
               rsp_in.out_band         = mix_ff[3];
               rsp_in.out_env = ((oflags_ff & FLAG_ENV) != '0) ? mix_ff[4] : '0;
               rsp_in.out_loc = ((oflags_ff & FLAG_LOC) != '0) ?
                                prev_val_ff[5] + shifted[31:0] : '0;
               rsp_in.last = (g_ff == ALL_ONES) || (cnt_ff + CW'(1) == CW'(MAX_BURST)) ||
                             (sat_add(g_ff, per_eff) > ts_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               lane_in  = lane_ff + 3'd1;
               state_in = S_MUL;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (ended_ff) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in  = cnt_ff + CW'(1);
                  frac_in = '0;
                  if (g_ff == ALL_ONES) begin
                     ended_in = 1'b1;
                     state_in = S_FINISH;
                  end else begin
                     ng_in    = sat_add(g_ff, per_eff);
                     state_in = S_LOOP;
                  end
               end
            end
         end
         S_FINISH: begin
            prev_ts_in    = ts_ff;
            prev_skew_in  = skew_ff;
            prev_flags_in = flags_ff;
            prev_val_in   = cur_ff;
            ended_in      = 1'b0;
            state_in      = S_IDLE;
            if (!ended_ff && ng_ff <= ts_ff) begin
               div_dividend = ts_ff - ng_ff;
               div_start    = 1'b1;
               state_in     = S_ADJ;
            end
         end
         S_ADJ: begin
            if (div_done) begin
               ng_in    = sat_add(ts_ff - div_rem, per_eff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         period_ff     <= PERIOD_RESET;
         gap_ff        <= MAX_GAP_RESET;
         have_prev_ff  <= 1'b0;
         prev_ts_ff    <= '0;
         prev_skew_ff  <= '0;
         prev_flags_ff <= '0;
         for (int i = 0; i < LANES; i++) begin
            prev_val_ff[i] <= '0;
         end
         ng_ff         <= '0;
         cnt_ff        <= '0;
         ended_ff      <= 1'b0;
         frac_ff       <= '0;
         lane_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         period_ff     <= period_in;
         gap_ff        <= gap_in;
         have_prev_ff  <= have_prev_in;
         prev_ts_ff    <= prev_ts_in;
         prev_skew_ff  <= prev_skew_in;
         prev_flags_ff <= prev_flags_in;
         prev_val_ff   <= prev_val_in;
         ng_ff         <= ng_in;
         cnt_ff        <= cnt_in;
         ended_ff      <= ended_in;
         frac_ff       <= frac_in;
         lane_ff       <= lane_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ts_ff     <= ts_in;
      skew_ff   <= skew_in;
      flags_ff  <= flags_in;
      cur_ff    <= cur_in;
      mix_ff    <= mix_in;
      span_ff   <= span_in;
      g_ff      <= g_in;
      oskew_ff  <= oskew_in;
      oflags_ff <= oflags_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
